>>> design/adcss_pkg.sv
// Shared types, constants and helper functions of the ADC channel scan sequencer.
package adcss_pkg;

    // Field widths
    localparam int CHAN_W   = 5;
    localparam int SAMPLE_W = 10;
    localparam int FS_W     = 16;
    localparam int MV_W     = 16;
    localparam int SLOT_W   = 3;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 4;
    localparam int PROD_W   = SAMPLE_W + FS_W;

    // Chain limits
    localparam int MAX_CHAIN   = 8;
    localparam int LIST_SLOTS  = 8;
    localparam int LIST_W      = LIST_SLOTS * CHAN_W;
    localparam int CHAIN_LIMIT = (MAX_CHAIN < LIST_SLOTS) ? MAX_CHAIN : LIST_SLOTS;

    // Result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register defaults
    localparam logic [LEN_W-1:0]  CHAIN_LENGTH_RESET = LEN_W'(1);
    localparam logic [LIST_W-1:0] CHANNEL_LIST_RESET = '0;
    localparam logic [FS_W-1:0]   FULL_SCALE_RESET   = FS_W'(5000);
    localparam logic              RES_MODE_RESET     = 1'b1;

    // Status codes
    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_BUSY     = 1'b1;

    // Resolution modes
    localparam logic RES_EIGHT_BIT = 1'b0;
    localparam logic RES_TEN_BIT   = 1'b1;

    typedef enum logic [1:0] {
        ACT_START_SINGLE = 2'd0,
        ACT_START_CHAIN  = 2'd1,
        ACT_COMPLETE     = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_START  = 2'd1,
        KIND_RESULT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_CHAIN_LENGTH = 2'd0,
        CFG_CHANNEL_LIST = 2'd1,
        CFG_FULL_SCALE   = 2'd2,
        CFG_RES_MODE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0]  chain_length;
        logic [LIST_W-1:0] channel_list;
        logic [FS_W-1:0]   full_scale;
        logic              res_mode;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic                status;
        logic [CHAN_W-1:0]   mux_channel;
        logic [SAMPLE_W-1:0] reading;
        logic [MV_W-1:0]     millivolts;
        logic [SLOT_W-1:0]   slot_index;
        logic                last;
    } result_t;

    // Channel number stored in a list slot; slots past the list read as zero
    function automatic logic [CHAN_W-1:0] list_channel(input logic [LIST_W-1:0] list,
                                                       input logic [POS_W-1:0]  slot);
        logic [CHAN_W-1:0] chan;
        chan = '0;
        if (32'(slot) < LIST_SLOTS) begin
            chan = list[CHAN_W * int'(slot[SLOT_W-1:0]) +: CHAN_W];
        end
        return chan;
    endfunction

    // Chain length clamped to at least one and at most the chain limit
    function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;
        eff = (len == '0) ? LEN_W'(1) : len;
        if (32'(eff) > CHAIN_LIMIT) begin
            eff = LEN_W'(CHAIN_LIMIT);
        end
        return eff;
    endfunction

endpackage

>>> design/adcss_cfg.sv
// Configuration register bank of the ADC channel scan sequencer.
module adcss_cfg
    import adcss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [LIST_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;

    // Always take a write request
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Update the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chain_length <= CHAIN_LENGTH_RESET;
            cfg_reg.channel_list <= CHANNEL_LIST_RESET;
            cfg_reg.full_scale   <= FULL_SCALE_RESET;
            cfg_reg.res_mode     <= RES_MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHAIN_LENGTH: cfg_reg.chain_length <= cfg_data[LEN_W-1:0];
                CFG_CHANNEL_LIST: cfg_reg.channel_list <= cfg_data[LIST_W-1:0];
                CFG_FULL_SCALE:   cfg_reg.full_scale   <= cfg_data[FS_W-1:0];
                CFG_RES_MODE:     cfg_reg.res_mode     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

endmodule

>>> design/adcss_core.sv
// Input register, job state and result generation of the ADC channel scan sequencer.
module adcss_core
    import adcss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_action,
    input  logic [CHAN_W-1:0]   in_channel,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  cfg_t                cfg,
    input  logic                room,
    output logic [1:0]          push_cnt,
    output result_t             res0,
    output result_t             res1
);

    logic                in_valid_reg;
    logic [1:0]          action_reg;
    logic [CHAN_W-1:0]   channel_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic                busy_reg,       busy_next;
    logic                chain_mode_reg, chain_mode_next;
    logic [POS_W-1:0]    chain_pos_reg,  chain_pos_next;

    logic                fire;
    logic [SAMPLE_W-1:0] reading;
    logic [PROD_W-1:0]   product;
    logic [MV_W-1:0]     millivolts;
    logic [POS_W-1:0]    pos_inc;

    // Process the held request once the queue has room for two results
    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;

    // Hold one request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            action_reg  <= in_action;
            channel_reg <= in_channel;
            sample_reg  <= in_sample;
        end
    end

    // Scale the reading to millivolts
    assign reading    = (cfg.res_mode == RES_TEN_BIT) ? sample_reg
                                                      : {2'b00, sample_reg[SAMPLE_W-1:2]};
    assign product    = PROD_W'(reading) * PROD_W'(cfg.full_scale);
    assign millivolts = (cfg.res_mode == RES_TEN_BIT) ? product[PROD_W-1:10] : product[23:8];
    assign pos_inc    = chain_pos_reg + POS_W'(1);

    // Build results and next job state
    always_comb begin
        busy_next       = busy_reg;
        chain_mode_next = chain_mode_reg;
        chain_pos_next  = chain_pos_reg;
        push_cnt        = 2'd0;
        res0            = '0;
        res1            = '0;
        res0.kind       = KIND_STATUS;
        res1.kind       = KIND_STATUS;
        if (fire) begin
            case (action_t'(action_reg))
                ACT_START_SINGLE, ACT_START_CHAIN: begin
                    if (busy_reg) begin
                        res0.status = STATUS_BUSY;
                        push_cnt    = 2'd1;
                    end else begin
                        busy_next        = 1'b1;
                        chain_pos_next   = '0;
                        chain_mode_next  = (action_t'(action_reg) == ACT_START_CHAIN);
                        res0.status      = STATUS_ACCEPTED;
                        res1.kind        = KIND_START;
                        res1.mux_channel = chain_mode_next
                                         ? list_channel(cfg.channel_list, '0) : channel_reg;
                        push_cnt         = 2'd2;
                    end
                end
                ACT_COMPLETE: begin
                    if (busy_reg) begin
                        res0.kind       = KIND_RESULT;
                        res0.reading    = reading;
                        res0.millivolts = millivolts;
                        push_cnt        = 2'd1;
                        if (!chain_mode_reg) begin
                            busy_next = 1'b0;
                            res0.last = 1'b1;
                        end else begin
                            res0.slot_index = chain_pos_reg[SLOT_W-1:0];
                            chain_pos_next  = pos_inc;
                            if (pos_inc >= effective_length(cfg.chain_length)) begin
                                busy_next = 1'b0;
                                res0.last = 1'b1;
                            end else begin
                                res1.kind        = KIND_START;
                                res1.mux_channel = list_channel(cfg.channel_list, pos_inc);
                                push_cnt         = 2'd2;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance job state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            chain_mode_reg <= 1'b0;
            chain_pos_reg  <= '0;
        end else begin
            busy_reg       <= busy_next;
            chain_mode_reg <= chain_mode_next;
            chain_pos_reg  <= chain_pos_next;
        end
    end

    // A job opens only with a status and a start command
    a_busy_rise_two: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> $past(push_cnt) == 2'd2)
        else $error("job started without status and command");

    // A job closes only with a final result
    a_busy_fall_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !busy_next |-> res0.kind == KIND_RESULT && res0.last)
        else $error("job ended without final result");

    // Nothing is produced without a processed request
    a_push_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> fire)
        else $error("result produced without request");

endmodule

>>> design/adcss_fifo.sv
// Result queue that parts the processing stage from the output channel.
module adcss_fifo
    import adcss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  result_t    res0,
    input  result_t    res1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (32'(count_reg) <= FIFO_DEPTH - 2);

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two results in order
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
        end
    end

    // Fill level stays within the queue
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= FIFO_DEPTH)
        else $error("queue fill level out of range");

    // A push never overruns the queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> 32'(count_reg) + 32'(push_cnt) <= FIFO_DEPTH)
        else $error("queue overflow");

    // Queue is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> count_reg == '0)
        else $error("queue not empty after reset");

endmodule

>>> design/adc_channel_scan_sequencer_top.sv
// Top level of the ADC channel scan sequencer.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tuser: action; tdata: channel, sample
//  m_*      | out       | tuser: kind; tdata: status..slot_index; tlast: last
//  cfg_*    | in        | cfg_index: register, cfg_data: value (always ready)
//
// A request is registered on acceptance and processed by one 10x16 scaling
// multiply and the chain state update; a new request can be taken every cycle
// while the queue has room for two. Each request yields zero, one or two results
// into a four-entry queue; processing waits for that room, so a stalled m_ side
// holds off s_ once more than two results are queued. Reset is synchronous and
// leaves the block idle, with the queue empty and registers at their defaults.
module adc_channel_scan_sequencer_top
    import adcss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // channel[4:0], sample[14:5], zero[15]
    input  logic [1:0]        s_tuser,   // action[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // status[0], mux_channel[5:1], reading[15:6],
                                         // millivolts[31:16], slot_index[34:32], zero[39:35]
    output logic [1:0]        m_tuser,   // kind[1:0]
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [LIST_W-1:0] cfg_data
);

    cfg_t       cfg;
    logic       room;
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;
    result_t    out_data;

    adcss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adcss_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_channel (s_tdata[CHAN_W-1:0]),
        .in_sample  (s_tdata[CHAN_W +: SAMPLE_W]),
        .cfg        (cfg),
        .room       (room),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    adcss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result fields onto the output channel
    assign m_tdata = {5'b00000, out_data.slot_index, out_data.millivolts, out_data.reading,
                      out_data.mux_channel, out_data.status};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule
